// ===== sv/node_slot_allocator_top_macros.svh =====
// ----------------------------------------------------------------------------
// node_slot_allocator_top_macros
// Assertion macros used by the node slot allocator checker.
// ----------------------------------------------------------------------------
`ifndef NODE_SLOT_ALLOCATOR_TOP_MACROS_SVH
`define NODE_SLOT_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define NSA_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication, disabled in reset
`define NSA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ===== sv/nsa_pkg.sv =====
// ----------------------------------------------------------------------------
// nsa_pkg
// Types and constants of the node slot allocator.
// ----------------------------------------------------------------------------
package nsa_pkg;

    localparam int SLOT_COUNT  = 256;
    localparam int STORE_DEPTH = 256;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int CNT_W       = 9;

    localparam logic [CNT_W-1:0] SLOT_LIMIT = CNT_W'(SLOT_COUNT);

    localparam logic [63:0] NULL_HANDLE  = 64'h0;
    localparam logic [31:0] NULL_NODE_ID = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        CMD_ALLOC     = 3'd0,
        CMD_RELEASE   = 3'd1,
        CMD_SET_DIRTY = 3'd2,
        CMD_CLR_DIRTY = 3'd3,
        CMD_WR_HANDLE = 3'd4,
        CMD_WR_NEXT   = 3'd5,
        CMD_READ      = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    typedef struct packed {
        cmd_t        command;
        logic [7:0]  slot_index;
        logic [63:0] data_word;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  result_index;
        logic [31:0] result_node_id;
        logic [63:0] result_handle;
        logic [31:0] result_next;
        logic        result_dirty;
        logic [8:0]  released_count;
    } out_item_t;

    typedef struct packed {
        logic [63:0] handle;
        logic [31:0] next;
        logic        dirty;
    } entry_t;

    localparam entry_t ENTRY_RESET = '{handle: NULL_HANDLE,
                                       next: NULL_NODE_ID,
                                       dirty: 1'b0};

    typedef struct packed {
        logic load;
        logic commit;
    } ctrl_cmd_t;

endpackage

// ===== sv/nsa_ram.sv =====
// ----------------------------------------------------------------------------
// nsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/nsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// nsa_ctrl
// Command sequencer and result handshake of the node slot allocator.
// ----------------------------------------------------------------------------
module nsa_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output nsa_pkg::ctrl_cmd_t cmd
);
    import nsa_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        cmd.load   = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            S_EXEC: begin
                cmd.commit = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== sv/nsa_datapath.sv =====
// ----------------------------------------------------------------------------
// nsa_datapath
// Slot store, free stack, bump pointer and result register.
// ----------------------------------------------------------------------------
module nsa_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  nsa_pkg::ctrl_cmd_t cmd,
    input  nsa_pkg::in_item_t  s_item,
    input  logic               cfg_wr_en,
    input  logic [31:0]        cfg_wr_data,
    output nsa_pkg::out_item_t m_item
);
    import nsa_pkg::*;

    logic [31:0]            base_reg;
    logic [CNT_W-1:0]       bump_reg;
    logic [CNT_W-1:0]       bump_next;
    logic [IDX_W-1:0]       top_reg;
    logic [IDX_W-1:0]       top_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [STORE_DEPTH-1:0] valid_reg;
    in_item_t               item_reg;
    logic [IDX_W-1:0]       addr_reg;
    out_item_t              out_reg;
    out_item_t              out_next;

    logic [IDX_W-1:0] addr_sel;
    entry_t           rd_entry;
    entry_t           cur;
    entry_t           upd;
    logic             wr_slot;
    logic             full;
    logic             overflow;

    always_comb begin
        if (s_item.command == CMD_ALLOC) begin
            if (count_reg != '0) begin
                addr_sel = top_reg;
            end else begin
                addr_sel = bump_reg[IDX_W-1:0];
            end
        end else begin
            addr_sel = s_item.slot_index[IDX_W-1:0];
        end
    end

    nsa_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (cmd.commit && wr_slot),
        .wr_addr (addr_reg),
        .wr_data (upd),
        .rd_en   (cmd.load),
        .rd_addr (addr_sel),
        .rd_data (rd_entry)
    );

    assign cur = valid_reg[addr_reg] ? rd_entry : ENTRY_RESET;

    always_comb begin
        upd        = cur;
        wr_slot    = 1'b0;
        full       = 1'b0;
        overflow   = 1'b0;
        bump_next  = bump_reg;
        top_next   = top_reg;
        count_next = count_reg;
        case (item_reg.command)
            CMD_ALLOC: begin
                if (count_reg != '0) begin
                    top_next   = cur.handle[IDX_W-1:0];
                    count_next = count_reg - 1'b1;
                    upd        = ENTRY_RESET;
                    wr_slot    = 1'b1;
                end else if (bump_reg < SLOT_LIMIT) begin
                    bump_next = bump_reg + 1'b1;
                    upd       = ENTRY_RESET;
                    wr_slot   = 1'b1;
                end else begin
                    full = 1'b1;
                end
            end
            CMD_RELEASE: begin
                if (count_reg >= SLOT_LIMIT) begin
                    overflow = 1'b1;
                end else begin
                    upd.handle = 64'(top_reg);
                    top_next   = addr_reg;
                    count_next = count_reg + 1'b1;
                    wr_slot    = 1'b1;
                end
            end
            CMD_SET_DIRTY: begin
                upd.dirty = 1'b1;
                wr_slot   = 1'b1;
            end
            CMD_CLR_DIRTY: begin
                upd.dirty = 1'b0;
                wr_slot   = 1'b1;
            end
            CMD_WR_HANDLE: begin
                upd.handle = item_reg.data_word;
                wr_slot    = 1'b1;
            end
            CMD_WR_NEXT: begin
                upd.next = item_reg.data_word[31:0];
                wr_slot  = 1'b1;
            end
            default: begin
                wr_slot = 1'b0;
            end
        endcase
    end

    always_comb begin
        out_next = '0;
        out_next.released_count = count_next;
        if (full) begin
            out_next.status = ST_FULL;
        end else begin
            out_next.status         = overflow ? ST_OVERFLOW : ST_OK;
            out_next.result_index   = 8'(addr_reg);
            out_next.result_node_id = base_reg + 32'(addr_reg);
            out_next.result_handle  = upd.handle;
            out_next.result_next    = upd.next;
            out_next.result_dirty   = upd.dirty;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= '0;
            bump_reg  <= '0;
            top_reg   <= '0;
            count_reg <= '0;
            valid_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                base_reg <= cfg_wr_data;
            end
            if (cmd.commit) begin
                bump_reg  <= bump_next;
                top_reg   <= top_next;
                count_reg <= count_next;
                if (wr_slot) begin
                    valid_reg[addr_reg] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_item;
            addr_reg <= addr_sel;
        end
        if (cmd.commit) begin
            out_reg <= out_next;
        end
    end

    assign m_item = out_reg;

endmodule

// ===== sv/node_slot_allocator_top.sv =====
// ----------------------------------------------------------------------------
// node_slot_allocator_top
// Free-list slot allocator with bump pointer for one group of node slots.
// ----------------------------------------------------------------------------
// Each command has a read step and an update step: the addressed slot entry
// is read from the single-port-read slot RAM in the accept cycle, and the
// update step merges the command, writes the entry back, updates the
// released-slot stack and bump pointer, and loads the result register. One
// command is in flight at a time; a new command is taken while the previous
// result still waits in the output register, and its update step holds until
// that result transfers. Reset needs no clearing pass: per-slot valid bits
// make an unwritten slot read as invalid handle, invalid next node, clean.
module node_slot_allocator_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  nsa_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output nsa_pkg::out_item_t m_item,
    input  logic               cfg_wr_en,
    input  logic [31:0]        cfg_wr_data
);
    import nsa_pkg::*;

    ctrl_cmd_t cmd;

    nsa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    nsa_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .s_item      (s_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_item      (m_item)
    );

endmodule

// ===== sv/nsa_checker.sv =====
// ----------------------------------------------------------------------------
// nsa_checker
// Port-level checks of the node slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "node_slot_allocator_top_macros.svh"

module nsa_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input nsa_pkg::out_item_t m_item
);
    import nsa_pkg::*;

    `NSA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_item))
    `NSA_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)
    `NSA_ASSERT_SAME(a_result_after_work, aclk, aresetn, $rose(m_valid), !$past(s_ready))
    `NSA_ASSERT_SAME(a_count_bound, aclk, aresetn, m_valid, m_item.released_count <= SLOT_LIMIT)
    `NSA_ASSERT_SAME(a_full_empty, aclk, aresetn, m_valid && m_item.status == ST_FULL,
                     m_item.result_index == '0 && m_item.result_handle == '0)

endmodule

bind node_slot_allocator_top nsa_checker u_nsa_checker (.*);

// ===== tb/node_slot_allocator_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// node_slot_allocator_top_tb
// Self-checking testbench of the node slot allocator. A behavioral copy of
// the slot stores, released-slot stack and bump pointer predicts every
// result. Directed tests cover reset contents, every command, the unused
// command code, double release, group full, release overflow and the node
// id base register at its extremes. Random traffic with random idling on
// both channels and forced backpressure follows.
// ----------------------------------------------------------------------------
module node_slot_allocator_top_tb;
    import nsa_pkg::*;

    localparam logic [2:0] CMD_UNUSED = 3'd7;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_item_t   s_item = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_item_t  m_item;
    logic       cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;

    logic [63:0] mdl_handle [STORE_DEPTH];
    logic [31:0] mdl_next [STORE_DEPTH];
    logic        mdl_dirty [STORE_DEPTH];
    logic [8:0]  mdl_bump;
    logic [7:0]  mdl_top;
    logic [8:0]  mdl_count;
    logic [31:0] mdl_base;

    out_item_t   slot_results_due [$];
    logic [7:0]  live_slots [$];
    int          mismatch_count = 0;
    int          hold_request = 0;
    bit          no_idle = 1'b0;

    node_slot_allocator_top u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic in_item_t make_item(cmd_t c, logic [7:0] s, logic [63:0] d);
        in_item_t it;
        it.command = c;
        it.slot_index = s;
        it.data_word = d;
        return it;
    endfunction

    function automatic out_item_t predict_slot_result(in_item_t it);
        out_item_t  r;
        logic [7:0] s;
        status_t    st;
        r = '0;
        s = it.slot_index;
        st = ST_OK;
        case (it.command)
            CMD_ALLOC: begin
                if (mdl_count != 0) begin
                    s = mdl_top;
                    mdl_top = mdl_handle[s][7:0];
                    mdl_count = mdl_count - 1'b1;
                end else if (mdl_bump < SLOT_LIMIT) begin
                    s = mdl_bump[7:0];
                    mdl_bump = mdl_bump + 1'b1;
                end else begin
                    st = ST_FULL;
                end
                if (st == ST_OK) begin
                    mdl_handle[s] = NULL_HANDLE;
                    mdl_next[s] = NULL_NODE_ID;
                    mdl_dirty[s] = 1'b0;
                end
            end
            CMD_RELEASE: begin
                if (mdl_count >= SLOT_LIMIT) begin
                    st = ST_OVERFLOW;
                end else begin
                    mdl_handle[s] = {56'd0, mdl_top};
                    mdl_top = s;
                    mdl_count = mdl_count + 1'b1;
                end
            end
            CMD_SET_DIRTY: mdl_dirty[s] = 1'b1;
            CMD_CLR_DIRTY: mdl_dirty[s] = 1'b0;
            CMD_WR_HANDLE: mdl_handle[s] = it.data_word;
            CMD_WR_NEXT:   mdl_next[s] = it.data_word[31:0];
            default: ;
        endcase
        r.status = st;
        r.released_count = mdl_count;
        if (st != ST_FULL) begin
            r.result_index = s;
            r.result_node_id = mdl_base + {24'd0, s};
            r.result_handle = mdl_handle[s];
            r.result_next = mdl_next[s];
            r.result_dirty = mdl_dirty[s];
        end
        return r;
    endfunction

    function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h actual %0h", field, want, got);
            mismatch_count++;
        end
    endfunction

    // Receiver: random stalls, forced hold-offs, gapless stretches.
    initial begin
        int hold_left;
        int stall_left;
        hold_left = 0;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (no_idle || $urandom_range(0, 3) != 0) begin
                m_ready <= 1'b1;
            end else begin
                stall_left = pick_gap() - 1;
                m_ready <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (slot_results_due.size() == 0) begin
                $error("result transfer with nothing pending: %p", m_item);
                mismatch_count++;
            end else begin
                want = slot_results_due.pop_front();
                check_field("status", want.status, m_item.status);
                check_field("result_index", want.result_index, m_item.result_index);
                check_field("result_node_id", want.result_node_id, m_item.result_node_id);
                check_field("result_handle", want.result_handle, m_item.result_handle);
                check_field("result_next", want.result_next, m_item.result_next);
                check_field("result_dirty", want.result_dirty, m_item.result_dirty);
                check_field("released_count", want.released_count, m_item.released_count);
            end
        end
    end

    task automatic send_cmd(in_item_t it);
        out_item_t due;
        int        hits [$];
        if (!no_idle && $urandom_range(0, 99) < 45) begin
            s_valid <= 1'b0;
            repeat (pick_gap()) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= it;
        do @(posedge aclk); while (!s_ready);
        due = predict_slot_result(it);
        slot_results_due.push_back(due);
        if (it.command == CMD_ALLOC && due.status == ST_OK) begin
            hits = live_slots.find_first_index(x) with (x == due.result_index);
            if (hits.size() == 0) begin
                live_slots.push_back(due.result_index);
            end
        end else if (it.command == CMD_RELEASE && due.status == ST_OK) begin
            hits = live_slots.find_first_index(x) with (x == it.slot_index);
            if (hits.size() != 0) begin
                live_slots.delete(hits[0]);
            end
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (slot_results_due.size() != 0);
    endtask

    task automatic write_base(logic [31:0] v);
        drain_results();
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        mdl_base = v;
    endtask

    task automatic test_commands();
        send_cmd(make_item(CMD_READ, 8'd0, 64'd0));
        send_cmd(make_item(cmd_t'(CMD_UNUSED), 8'd255, '1));
        repeat (3) send_cmd(make_item(CMD_ALLOC, 8'd200, '1));
        send_cmd(make_item(CMD_WR_HANDLE, 8'd1, '1));
        send_cmd(make_item(CMD_WR_HANDLE, 8'd2, 64'd0));
        send_cmd(make_item(CMD_WR_NEXT, 8'd1, 64'hFFFF_FFFF_0000_0000));
        send_cmd(make_item(CMD_WR_NEXT, 8'd2, '1));
        send_cmd(make_item(CMD_SET_DIRTY, 8'd1, 64'd0));
        send_cmd(make_item(CMD_SET_DIRTY, 8'd255, 64'd0));
        send_cmd(make_item(CMD_CLR_DIRTY, 8'd255, 64'd0));
        send_cmd(make_item(CMD_READ, 8'd1, 64'd0));
        send_cmd(make_item(CMD_RELEASE, 8'd1, '1));
        send_cmd(make_item(CMD_RELEASE, 8'd2, 64'd0));
        send_cmd(make_item(CMD_RELEASE, 8'd2, 64'd0));
        repeat (3) send_cmd(make_item(CMD_ALLOC, 8'd0, 64'd0));
        send_cmd(make_item(CMD_READ, 8'd2, 64'd0));
        send_cmd(make_item(CMD_WR_HANDLE, 8'd255, {$urandom, $urandom}));
        send_cmd(make_item(CMD_READ, 8'd255, 64'd0));
    endtask

    task automatic test_base_register();
        logic [31:0] bases [5];
        bases = '{32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'd0};
        foreach (bases[i]) begin
            write_base(bases[i]);
            send_cmd(make_item(CMD_READ, 8'd255, 64'd0));
            send_cmd(make_item(CMD_READ, 8'd0, 64'd0));
            send_cmd(make_item(CMD_ALLOC, 8'd0, 64'd0));
        end
    endtask

    task automatic test_group_full();
        while (!(mdl_count == 0 && mdl_bump == SLOT_LIMIT)) begin
            send_cmd(make_item(CMD_ALLOC, 8'($urandom), {$urandom, $urandom}));
        end
        repeat (3) send_cmd(make_item(CMD_ALLOC, 8'($urandom), '1));
        repeat (4) send_cmd(make_item(CMD_RELEASE, 8'($urandom), 64'd0));
        repeat (5) send_cmd(make_item(CMD_ALLOC, 8'd0, 64'd0));
    endtask

    task automatic test_release_overflow();
        while (mdl_count < SLOT_LIMIT) begin
            send_cmd(make_item(CMD_RELEASE, 8'($urandom), {$urandom, $urandom}));
        end
        repeat (3) send_cmd(make_item(CMD_RELEASE, 8'($urandom), '1));
        repeat (258) send_cmd(make_item(CMD_ALLOC, 8'($urandom), 64'd0));
    endtask

    task automatic test_backpressure();
        drain_results();
        no_idle = 1'b1;
        hold_request = 300;
        for (int i = 0; i < 30; i++) begin
            send_cmd(make_item(cmd_t'($urandom_range(0, 6)), 8'($urandom),
                               {$urandom, $urandom}));
        end
        no_idle = 1'b0;
        drain_results();
    endtask

    task automatic test_random_traffic(int n_items);
        int         alloc_bias;
        int         pick;
        cmd_t       c;
        logic [7:0] s;
        alloc_bias = 40;
        for (int i = 0; i < n_items; i++) begin
            if (i % 64 == 0) begin
                alloc_bias = $urandom_range(5, 90);
            end
            if (i % 200 == 0) begin
                no_idle = ($urandom_range(0, 3) == 0);
            end
            if (i % 350 == 349) begin
                write_base($urandom);
            end
            if ($urandom_range(0, 99) == 0) begin
                drain_results();
            end
            pick = $urandom_range(0, 99);
            if (pick < alloc_bias) begin
                c = CMD_ALLOC;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 40) c = CMD_RELEASE;
                else if (pick < 52) c = CMD_SET_DIRTY;
                else if (pick < 62) c = CMD_CLR_DIRTY;
                else if (pick < 74) c = CMD_WR_HANDLE;
                else if (pick < 86) c = CMD_WR_NEXT;
                else if (pick < 96) c = CMD_READ;
                else c = cmd_t'(CMD_UNUSED);
            end
            if (live_slots.size() != 0 && $urandom_range(0, 99) < 85) begin
                s = live_slots[$urandom_range(0, live_slots.size() - 1)];
            end else begin
                s = 8'($urandom);
            end
            send_cmd(make_item(c, s, {$urandom, $urandom}));
        end
        no_idle = 1'b0;
    endtask

    initial begin
        foreach (mdl_handle[i]) begin
            mdl_handle[i] = NULL_HANDLE;
            mdl_next[i] = NULL_NODE_ID;
            mdl_dirty[i] = 1'b0;
        end
        mdl_bump = '0;
        mdl_top = '0;
        mdl_count = '0;
        mdl_base = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_commands();
        test_base_register();
        test_group_full();
        test_release_overflow();
        test_backpressure();
        test_random_traffic(1000);
        drain_results();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("node_slot_allocator_top regression: pass");
        end else begin
            $display("node_slot_allocator_top regression: fail");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("node_slot_allocator_top regression: fail");
        $finish;
    end

endmodule

// ===== node_slot_allocator_top.f =====
+incdir+sv
sv/nsa_pkg.sv
sv/nsa_ram.sv
sv/nsa_ctrl.sv
sv/nsa_datapath.sv
sv/node_slot_allocator_top.sv
sv/nsa_checker.sv
tb/node_slot_allocator_top_tb.sv
